[hw/rtl/dq_current_pi_with_vector_limit_top_defines.svh]
// Assertion macros for the d/q current PI controller.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef DQ_CURRENT_PI_WITH_VECTOR_LIMIT_TOP_DEFINES_SVH
`define DQ_CURRENT_PI_WITH_VECTOR_LIMIT_TOP_DEFINES_SVH

// same-cycle implication
`define DQPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DQPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/dqpi_pkg.sv]
// Shared types and constants of the d/q current PI controller.
// No dependencies.
package dqpi_pkg;

    localparam int DATA_W        = 16;
    localparam int LIM_W         = 15;
    localparam logic [15:0] STEP_TIME_MIN = 16'd1;
    localparam int SQRT_STEPS    = 16;
    localparam int DIV_STEPS     = 32;
    localparam int REM_W         = 20;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_BAD_LIMIT = 2'd1,
        RC_BAD_STEP  = 2'd2
    } t_result_code;

    typedef enum logic [2:0] {
        CFG_KP_D  = 3'd0,
        CFG_KI_D  = 3'd1,
        CFG_KP_Q  = 3'd2,
        CFG_KI_Q  = 3'd3,
        CFG_I_LOW = 3'd4,
        CFG_I_HIGH = 3'd5,
        CFG_VLIM  = 3'd6,
        CFG_TSMAX = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_PD, S_PQ, S_SD, S_SQ, S_LL, S_CMP, S_MAG,
        S_AD, S_DD, S_DDW, S_AQ, S_DQ, S_DQW,
        S_KD1, S_KD2, S_KD3, S_KQ1, S_KQ2, S_KQ3,
        S_LD, S_LQ, S_LS, S_LW, S_OUT
    } t_state;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } t_unit_op;

    typedef struct packed {
        logic        start;
        t_unit_op    op;
        logic [31:0] operand;
        logic [15:0] divisor;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] result;
    } t_unit_rsp;

    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [51:0] v);
        logic signed [51:0] hi;
        logic signed [51:0] lo;
        hi = 52'sd32767;
        lo = -52'sd32768;
        if (v > hi) begin
            sat_word = 16'sh7FFF;
        end else if (v < lo) begin
            sat_word = 16'sh8000;
        end else begin
            sat_word = v[DATA_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/dqpi_in_if.sv]
// Input channel of the d/q current PI controller: valid/ready plus one item.
// No dependencies.
interface dqpi_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] id_reference;
    logic signed [15:0] id_measured;
    logic signed [15:0] iq_reference;
    logic signed [15:0] iq_measured;
    logic [15:0]        step_time;

    modport source (output valid, id_reference, id_measured, iq_reference, iq_measured,
                    step_time, input ready);
    modport sink   (input valid, id_reference, id_measured, iq_reference, iq_measured,
                    step_time, output ready);
endinterface

[hw/rtl/dqpi_out_if.sv]
// Result channel of the d/q current PI controller: valid/ready plus one item.
// No dependencies.
interface dqpi_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vd_limited;
    logic signed [15:0] vq_limited;
    logic signed [15:0] vd_unlimited;
    logic signed [15:0] vq_unlimited;
    logic [14:0]        vector_length;
    logic               vector_clipped;
    logic               d_clipped;
    logic               q_clipped;
    logic [1:0]         result_code;

    modport source (output valid, vd_limited, vq_limited, vd_unlimited, vq_unlimited,
                    vector_length, vector_clipped, d_clipped, q_clipped, result_code,
                    input ready);
    modport sink   (input valid, vd_limited, vq_limited, vd_unlimited, vq_unlimited,
                    vector_length, vector_clipped, d_clipped, q_clipped, result_code,
                    output ready);
endinterface

[hw/rtl/dqpi_iter_unit.sv]
// Shared iterative unit: 32-bit integer square root (2 bits per cycle)
// or 32 by 16 bit unsigned divide (1 bit per cycle). Uses dqpi_pkg.
module dqpi_iter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dqpi_pkg::t_unit_req i_req,
    output dqpi_pkg::t_unit_rsp o_rsp
);
    import dqpi_pkg::*;

    logic [31:0]      r_x, n_x;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [31:0]      r_res, n_res;
    logic [4:0]       r_cnt, n_cnt;
    logic [15:0]      r_div, n_div;
    t_unit_op         r_op, n_op;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [REM_W-1:0] w_rem_s;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    always_comb begin
        if (r_op == OP_SQRT) begin
            w_rem_s = {r_rem[REM_W-3:0], r_x[31:30]};
            w_trial = {r_res[REM_W-3:0], 2'b01};
        end else begin
            w_rem_s = {r_rem[REM_W-2:0], r_x[31]};
            w_trial = {{(REM_W-16){1'b0}}, r_div};
        end
        w_ge = (w_rem_s >= w_trial);
    end

    always_comb begin
        n_x    = r_x;
        n_rem  = r_rem;
        n_res  = r_res;
        n_cnt  = r_cnt;
        n_div  = r_div;
        n_op   = r_op;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_x    = i_req.operand;
            n_rem  = '0;
            n_res  = '0;
            n_div  = i_req.divisor;
            n_op   = i_req.op;
            n_cnt  = (i_req.op == OP_SQRT) ? 5'(SQRT_STEPS - 1) : 5'(DIV_STEPS - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = w_ge ? (w_rem_s - w_trial) : w_rem_s;
            n_res = {r_res[30:0], w_ge};
            n_x   = (r_op == OP_SQRT) ? {r_x[29:0], 2'b00} : {r_x[30:0], 1'b0};
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= OP_SQRT;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_rem <= n_rem;
        r_res <= n_res;
        r_div <= n_div;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

[hw/rtl/dq_current_pi_with_vector_limit_top.sv]
// d/q current PI controller with a circular voltage vector limit. One item
// is taken at a time: the input is not ready until the result has been taken.
// A rejected item (bad limit or step time) goes straight to the result. The
// work per item is done by one shared multiplier (one product per cycle) and
// one shared iterative unit that computes square roots and quotients (one
// vector-length root always, plus one root and two divides when clipping).
// Uses dqpi_pkg, dqpi_in_if, dqpi_out_if, dqpi_iter_unit and the defines header.
`include "dq_current_pi_with_vector_limit_top_defines.svh"

module dq_current_pi_with_vector_limit_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    dqpi_in_if.sink     i_in,
    dqpi_out_if.source  o_out
);
    import dqpi_pkg::*;

    // configuration
    logic [15:0]        r_kp_d, r_ki_d, r_kp_q, r_ki_q;
    logic signed [15:0] r_ilo, r_ihi;
    logic [LIM_W-1:0]   r_vlim;
    logic [15:0]        r_tsmax;

    // control and state
    t_state             r_state, n_state;
    logic signed [15:0] r_integ_d, r_integ_q;
    logic               r_clip;
    logic [31:0]        r_update_count;

    // datapath
    logic signed [16:0] r_err_d, r_err_q;
    logic [15:0]        r_ts;
    logic signed [15:0] r_rd, r_rq, r_ld, r_lq;
    logic [31:0]        r_acc;
    logic [15:0]        r_mag;
    logic signed [50:0] r_prod;

    // output register
    logic               r_ovalid;
    logic signed [15:0] r_o_vd, r_o_vq, r_o_rd, r_o_rq;
    logic [14:0]        r_o_len;
    logic               r_o_vclip, r_o_dclip, r_o_qclip;
    t_result_code       r_o_code;

    logic signed [32:0] w_mul_a;
    logic signed [17:0] w_mul_b;
    logic signed [50:0] w_prod;
    logic signed [15:0] w_integ_sel;
    logic signed [51:0] w_psum;
    logic signed [15:0] w_integ_new;
    logic               w_bad_lim, w_bad_ts;
    logic               w_accept;
    logic [16:0]        w_abs_rd, w_abs_rq;
    logic [14:0]        w_quot;
    logic               w_sat_d, w_sat_q;
    logic               w_keep_d, w_keep_q;
    t_unit_req          w_req;
    t_unit_rsp          w_rsp;

    dqpi_iter_unit u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_accept  = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    assign w_bad_lim = (r_vlim == '0) || (r_ilo > r_ihi);
    assign w_bad_ts  = (i_in.step_time == 16'd0) || (r_tsmax < STEP_TIME_MIN) ||
                       (i_in.step_time < STEP_TIME_MIN) || (i_in.step_time > r_tsmax);

    assign w_abs_rd = r_rd[15] ? 17'(-{r_rd[15], r_rd}) : {1'b0, r_rd};
    assign w_abs_rq = r_rq[15] ? 17'(-{r_rq[15], r_rq}) : {1'b0, r_rq};
    assign w_quot   = w_rsp.result[14:0];

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            S_PD: begin
                w_mul_a = $signed({17'd0, r_kp_d});
                w_mul_b = $signed({r_err_d[16], r_err_d});
            end
            S_PQ: begin
                w_mul_a = $signed({17'd0, r_kp_q});
                w_mul_b = $signed({r_err_q[16], r_err_q});
            end
            S_SD: begin
                w_mul_a = 33'(r_rd);
                w_mul_b = 18'(r_rd);
            end
            S_SQ: begin
                w_mul_a = 33'(r_rq);
                w_mul_b = 18'(r_rq);
            end
            S_LL: begin
                w_mul_a = $signed({18'd0, r_vlim});
                w_mul_b = $signed({3'd0, r_vlim});
            end
            S_AD: begin
                w_mul_a = $signed({16'd0, w_abs_rd});
                w_mul_b = $signed({3'd0, r_vlim});
            end
            S_AQ: begin
                w_mul_a = $signed({16'd0, w_abs_rq});
                w_mul_b = $signed({3'd0, r_vlim});
            end
            S_KD1: begin
                w_mul_a = $signed({17'd0, r_ki_d});
                w_mul_b = $signed({2'd0, r_ts});
            end
            S_KQ1: begin
                w_mul_a = $signed({17'd0, r_ki_q});
                w_mul_b = $signed({2'd0, r_ts});
            end
            S_KD2: begin
                w_mul_a = $signed({1'b0, r_prod[31:0]});
                w_mul_b = $signed({r_err_d[16], r_err_d});
            end
            S_KQ2: begin
                w_mul_a = $signed({1'b0, r_prod[31:0]});
                w_mul_b = $signed({r_err_q[16], r_err_q});
            end
            S_LD: begin
                w_mul_a = 33'(r_ld);
                w_mul_b = 18'(r_ld);
            end
            S_LQ: begin
                w_mul_a = 33'(r_lq);
                w_mul_b = 18'(r_lq);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // floor(product / 256) plus the integrator of the axis in work
    assign w_integ_sel = ((r_state == S_PQ) || (r_state == S_KD3)) ? r_integ_d : r_integ_q;
    assign w_psum = ($signed({r_prod[50], r_prod}) >>> 8) + 52'(w_integ_sel);

    always_comb begin
        if (w_psum < 52'(r_ilo)) begin
            w_integ_new = r_ilo;
        end else if (w_psum > 52'(r_ihi)) begin
            w_integ_new = r_ihi;
        end else begin
            w_integ_new = w_psum[15:0];
        end
    end

    // anti-windup: hold when saturated and error pushes the same way as the output
    assign w_sat_d  = (r_ld != r_rd);
    assign w_sat_q  = (r_lq != r_rq);
    assign w_keep_d = w_sat_d &&
        ((!r_err_d[16] && r_err_d != '0 && !r_rd[15] && r_rd != '0) ||
         (r_err_d[16] && r_rd[15]));
    assign w_keep_q = w_sat_q &&
        ((!r_err_q[16] && r_err_q != '0 && !r_rq[15] && r_rq != '0) ||
         (r_err_q[16] && r_rq[15]));

    always_comb begin
        n_state       = r_state;
        w_req.start   = 1'b0;
        w_req.op      = OP_SQRT;
        w_req.operand = r_acc;
        w_req.divisor = r_mag;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (w_bad_lim || w_bad_ts) ? S_OUT : S_PD;
                end
            end
            S_PD:  n_state = S_PQ;
            S_PQ:  n_state = S_SD;
            S_SD:  n_state = S_SQ;
            S_SQ:  n_state = S_LL;
            S_LL:  n_state = S_CMP;
            S_CMP: begin
                if (r_acc > r_prod[31:0]) begin
                    w_req.start = 1'b1;
                    n_state     = S_MAG;
                end else begin
                    n_state = S_KD1;
                end
            end
            S_MAG: if (w_rsp.done) n_state = S_AD;
            S_AD:  n_state = S_DD;
            S_DD: begin
                w_req.start   = 1'b1;
                w_req.op      = OP_DIV;
                w_req.operand = r_prod[31:0];
                n_state       = S_DDW;
            end
            S_DDW: if (w_rsp.done) n_state = S_AQ;
            S_AQ:  n_state = S_DQ;
            S_DQ: begin
                w_req.start   = 1'b1;
                w_req.op      = OP_DIV;
                w_req.operand = r_prod[31:0];
                n_state       = S_DQW;
            end
            S_DQW: if (w_rsp.done) n_state = S_KD1;
            S_KD1: n_state = S_KD2;
            S_KD2: n_state = S_KD3;
            S_KD3: n_state = S_KQ1;
            S_KQ1: n_state = S_KQ2;
            S_KQ2: n_state = S_KQ3;
            S_KQ3: n_state = S_LD;
            S_LD:  n_state = S_LQ;
            S_LQ:  n_state = S_LS;
            S_LS: begin
                w_req.start   = 1'b1;
                w_req.operand = r_acc + r_prod[31:0];
                n_state       = S_LW;
            end
            S_LW:  if (w_rsp.done) n_state = S_OUT;
            S_OUT: if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp_d  <= 16'd256;
            r_ki_d  <= 16'd0;
            r_kp_q  <= 16'd256;
            r_ki_q  <= 16'd0;
            r_ilo   <= -16'sd32768;
            r_ihi   <= 16'sd32767;
            r_vlim  <= '1;
            r_tsmax <= 16'hFFFF;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KP_D:   r_kp_d  <= i_cfg_data;
                CFG_KI_D:   r_ki_d  <= i_cfg_data;
                CFG_KP_Q:   r_kp_q  <= i_cfg_data;
                CFG_KI_Q:   r_ki_q  <= i_cfg_data;
                CFG_I_LOW:  r_ilo   <= i_cfg_data;
                CFG_I_HIGH: r_ihi   <= i_cfg_data;
                CFG_VLIM:   r_vlim  <= i_cfg_data[LIM_W-1:0];
                CFG_TSMAX:  r_tsmax <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ_d      <= '0;
            r_integ_q      <= '0;
            r_clip         <= 1'b0;
            r_update_count <= '0;
            r_ovalid       <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_bad_lim || w_bad_ts)) begin
                        r_ovalid <= 1'b1;
                    end
                end
                S_CMP:  r_clip <= (r_acc > r_prod[31:0]);
                S_KD3:  if (!w_keep_d) r_integ_d <= w_integ_new;
                S_KQ3:  if (!w_keep_q) r_integ_q <= w_integ_new;
                S_LW: begin
                    if (w_rsp.done) begin
                        r_update_count <= r_update_count + 32'd1;
                        r_ovalid       <= 1'b1;
                    end
                end
                S_OUT:  if (o_out.ready) r_ovalid <= 1'b0;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_err_d <= 17'(i_in.id_reference) - 17'(i_in.id_measured);
                    r_err_q <= 17'(i_in.iq_reference) - 17'(i_in.iq_measured);
                    r_ts    <= i_in.step_time;
                    r_o_vd    <= '0;
                    r_o_vq    <= '0;
                    r_o_rd    <= '0;
                    r_o_rq    <= '0;
                    r_o_len   <= '0;
                    r_o_vclip <= 1'b0;
                    r_o_dclip <= 1'b0;
                    r_o_qclip <= 1'b0;
                    r_o_code  <= w_bad_lim ? RC_BAD_LIMIT :
                                 (w_bad_ts ? RC_BAD_STEP : RC_OK);
                end
            end
            S_PQ:  r_rd  <= sat_word(w_psum);
            S_SD:  r_rq  <= sat_word(w_psum);
            S_SQ:  r_acc <= r_prod[31:0];
            S_LL:  r_acc <= r_acc + r_prod[31:0];
            S_CMP: begin
                r_ld <= r_rd;
                r_lq <= r_rq;
            end
            S_MAG: if (w_rsp.done) r_mag <= w_rsp.result[15:0];
            S_DDW: begin
                if (w_rsp.done) begin
                    r_ld <= r_rd[15] ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
                end
            end
            S_DQW: begin
                if (w_rsp.done) begin
                    r_lq <= r_rq[15] ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
                end
            end
            S_LQ:  r_acc <= r_prod[31:0];
            S_LW: begin
                if (w_rsp.done) begin
                    r_o_vd    <= r_ld;
                    r_o_vq    <= r_lq;
                    r_o_rd    <= r_rd;
                    r_o_rq    <= r_rq;
                    r_o_len   <= w_rsp.result[15] ? 15'h7FFF : w_rsp.result[14:0];
                    r_o_vclip <= r_clip;
                    r_o_dclip <= w_sat_d;
                    r_o_qclip <= w_sat_q;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.vd_limited     = r_o_vd;
    assign o_out.vq_limited     = r_o_vq;
    assign o_out.vd_unlimited   = r_o_rd;
    assign o_out.vq_unlimited   = r_o_rq;
    assign o_out.vector_length  = r_o_len;
    assign o_out.vector_clipped = r_o_vclip;
    assign o_out.d_clipped      = r_o_dclip;
    assign o_out.q_clipped      = r_o_qclip;
    assign o_out.result_code    = r_o_code;

    `DQPI_ASSERT_NOW(a_one_item, o_out.valid, !i_in.ready, "input ready while a result waits")
    `DQPI_ASSERT_NOW(a_axis_clip, o_out.valid && (o_out.d_clipped || o_out.q_clipped),
        o_out.vector_clipped, "axis clipped without vector clip")
    `DQPI_ASSERT_NEXT(a_count_hold, r_state == S_IDLE, $stable(r_update_count),
        "update count moved while idle")
    `DQPI_ASSERT_NOW(a_unit_quiet, r_state == S_IDLE || r_state == S_OUT, !w_rsp.busy,
        "iterative unit busy outside a computation")

endmodule
